// ===== rtl/core/rsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

   // Pixels in one frame; a span whose end passes this count is flagged.
   localparam logic [16:0] FRAME_PIXELS = 17'd65536;

   // Opcode bytes and word markers of the stream
   localparam logic [7:0]  OP_SHORT_RUN = 8'h00;
   localparam logic [7:0]  OP_LONG_FORM = 8'h80;
   localparam logic [15:0] WORD_STOP    = 16'h0000;

   typedef enum logic [4:0] {
      PH_OP        = 5'b00001,
      PH_DUMP      = 5'b00010,
      PH_RUN_COUNT = 5'b00100,
      PH_RUN_VALUE = 5'b01000,
      PH_WORD      = 5'b10000
   } rsd_phase_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] span_start;
      logic [13:0] span_length;
      logic [7:0]  pixel_value;
      logic        frame_done;
      logic        out_of_frame;
   } rsd_span_type;

endpackage

`default_nettype wire

// ===== rtl/core/run_skip_dump_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_code_byte
// rsp_      out        rsp_valid / rsp_stall  rsp_span_start, rsp_span_length,
//                                             rsp_pixel_value, rsp_frame_done,
//                                             rsp_out_of_frame
//
// One item a cycle while rsp_ is not stalled: each byte is held in the input
// register, then the decode logic updates phase and position and loads the
// result register. Synchronous reset empties both registers and rewinds
// to the opcode phase. A stall on rsp_ backs up into req_stall only once
// both registers are full.

module run_skip_dump_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_code_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [15:0] rsp_span_start,
   output      logic [13:0] rsp_span_length,
   output      logic [7:0]  rsp_pixel_value,
   output      logic        rsp_frame_done,
   output      logic        rsp_out_of_frame
);
   import rsd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         out_free;
   logic         advance;
   logic         out_valid_ff, out_valid_in;
   rsd_span_type span;
   rsd_span_type out_ff;

   // The result register can take a new value when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Hold the byte while the result side is blocked, else refill
   assign in_valid_in = advance ? req_valid : (in_valid_ff || req_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_code_byte;
      end
   end

   rsd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .code_byte (in_byte_ff),
      .span      (span)
   );

   // Load a span only for bytes that produce one; drop the slot otherwise
   assign out_valid_in = out_free ? (advance && span.valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= span;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_span_start   = out_ff.span_start;
   assign rsp_span_length  = out_ff.span_length;
   assign rsp_pixel_value  = out_ff.pixel_value;
   assign rsp_frame_done   = out_ff.frame_done;
   assign rsp_out_of_frame = out_ff.out_of_frame;

endmodule

`default_nettype wire

// ===== rtl/core/rsd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsd_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            code_byte,
   output      rsd_pkg::rsd_span_type span
);
   import rsd_pkg::*;

   rsd_phase_type phase_ff, phase_in;
   logic [13:0]   pending_ff, pending_in;
   logic [7:0]    low_byte_ff, low_byte_in;
   logic [15:0]   position_ff, position_in;
   logic          long_ff, long_in;

   logic [15:0]   word;
   logic [16:0]   span_end;

   assign word = {code_byte, low_byte_ff};

   always_comb begin
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      low_byte_in = low_byte_ff;
      position_in = position_ff;
      long_in     = long_ff;

      span.valid        = 1'b0;
      span.span_start   = position_ff;
      span.span_length  = 14'd0;
      span.pixel_value  = code_byte;
      span.frame_done   = 1'b0;

      unique case (phase_ff)
         PH_DUMP: begin
            // emit one literal pixel, count down
            span.valid       = 1'b1;
            span.span_length = 14'd1;
            position_in      = position_ff + 16'd1;
            pending_in       = pending_ff - 14'd1;
            if (pending_ff == 14'd1) begin
               phase_in = PH_OP;
            end
         end
         PH_RUN_COUNT: begin
            pending_in = {6'd0, code_byte};
            phase_in   = PH_RUN_VALUE;
         end
         PH_RUN_VALUE: begin
            phase_in   = PH_OP;
            pending_in = 14'd0;
            if (pending_ff != 14'd0) begin
               span.valid       = 1'b1;
               span.span_length = pending_ff;
               position_in      = position_ff + {2'd0, pending_ff};
            end
         end
         PH_WORD: begin
            if (!long_ff) begin
               low_byte_in = code_byte;
               long_in     = 1'b1;
            end else begin
               long_in  = 1'b0;
               phase_in = PH_OP;
               if (word == WORD_STOP) begin
                  // close the frame and rewind
                  span.valid       = 1'b1;
                  span.pixel_value = 8'd0;
                  span.frame_done  = 1'b1;
                  position_in      = 16'd0;
               end else if (!word[15]) begin
                  position_in = position_ff + word;
               end else if (word[14]) begin
                  pending_in = word[13:0];
                  phase_in   = PH_RUN_VALUE;
               end else if (word[13:0] != 14'd0) begin
                  pending_in = word[13:0];
                  phase_in   = PH_DUMP;
               end
            end
         end
         default: begin
            if (code_byte == OP_SHORT_RUN) begin
               phase_in = PH_RUN_COUNT;
            end else if (!code_byte[7]) begin
               pending_in = {6'd0, code_byte};
               phase_in   = PH_DUMP;
            end else if (code_byte == OP_LONG_FORM) begin
               long_in  = 1'b0;
               phase_in = PH_WORD;
            end else begin
               position_in = position_ff + {9'd0, code_byte[6:0]};
            end
         end
      endcase

      span_end          = {1'b0, position_ff} + {3'd0, span.span_length};
      span.out_of_frame = !span.frame_done && (span_end > FRAME_PIXELS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OP;
         pending_ff  <= 14'd0;
         low_byte_ff <= 8'd0;
         position_ff <= 16'd0;
         long_ff     <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pending_ff  <= pending_in;
         low_byte_ff <= low_byte_in;
         position_ff <= position_in;
         long_ff     <= long_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_span_start,
   input wire logic [13:0] rsp_span_length,
   input wire logic [7:0]  rsp_pixel_value,
   input wire logic        rsp_frame_done,
   input wire logic        rsp_out_of_frame
);

   // Frame done carries an empty, unflagged span
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         rsp_span_length == 14'd0 && rsp_pixel_value == 8'd0 && !rsp_out_of_frame)
      else $error("frame done span not empty");

   // Pixel spans never have zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_span_length != 14'd0)
      else $error("zero length pixel span");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_span_start)
         && $stable(rsp_span_length) && $stable(rsp_pixel_value))
      else $error("stalled result changed");

endmodule

bind run_skip_dump_decoder_core rsd_checker u_rsd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_span_start   (rsp_span_start),
   .rsp_span_length  (rsp_span_length),
   .rsp_pixel_value  (rsp_pixel_value),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_out_of_frame (rsp_out_of_frame)
);

`default_nettype wire

// ===== tb/run_skip_dump_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module run_skip_dump_decoder_core_tb;

   import rsd_pkg::*;

   // Word markers after the long-form opcode
   localparam logic [15:0] LONG_DUMP_BASE  = 16'h8000;
   localparam logic [15:0] LONG_RUN_BASE   = 16'hC000;
   localparam logic [15:0] LONG_RUN_OFFSET = 16'h4000;

   localparam int ITEM_TARGET     = 1100;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 8;

   // Tracks the decoder's phase and position and holds the spans still owed.
   class span_scoreboard;
      rsd_phase_type phase;
      logic [14:0]   pending;
      logic [7:0]    held_low;
      logic [15:0]   position;
      logic          long_form;
      rsd_span_type  span_q[$];
      int            errors;

      function new();
         phase     = PH_OP;
         pending   = '0;
         held_low  = '0;
         position  = '0;
         long_form = 1'b0;
         errors    = 0;
      endfunction

      function void push_span(logic [15:0] start, logic [13:0] len, logic [7:0] val);
         rsd_span_type s;
         s              = '0;
         s.valid        = 1'b1;
         s.span_start   = start;
         s.span_length  = len;
         s.pixel_value  = val;
         s.out_of_frame = ({1'b0, start} + 17'(len)) > FRAME_PIXELS;
         span_q.push_back(s);
      endfunction

      // Advance the decoder state by one accepted byte.
      function void note_byte(logic [7:0] b);
         logic [15:0]  word;
         logic [15:0]  n;
         rsd_span_type s;
         case (phase)
            PH_DUMP: begin
               push_span(position, 14'd1, b);
               position = position + 16'd1;
               pending  = pending - 15'd1;
               if (pending == '0)
                  phase = PH_OP;
            end
            PH_RUN_COUNT: begin
               pending = {7'd0, b};
               phase   = PH_RUN_VALUE;
            end
            PH_RUN_VALUE: begin
               phase   = PH_OP;
               n       = {1'b0, pending};
               pending = '0;
               if (n != '0) begin
                  push_span(position, n[13:0], b);
                  position = position + n;
               end
            end
            PH_WORD: begin
               if (!long_form) begin
                  held_low  = b;
                  long_form = 1'b1;
               end else begin
                  long_form = 1'b0;
                  phase     = PH_OP;
                  word      = {b, held_low};
                  if (word == WORD_STOP) begin
                     s            = '0;
                     s.valid      = 1'b1;
                     s.span_start = position;
                     s.frame_done = 1'b1;
                     span_q.push_back(s);
                     position = '0;
                  end else if (!word[15]) begin
                     position = position + word;
                  end else begin
                     n = word - LONG_DUMP_BASE;
                     if (n >= LONG_RUN_OFFSET) begin
                        pending = 15'(n - LONG_RUN_OFFSET);
                        phase   = PH_RUN_VALUE;
                     end else if (n != '0) begin
                        pending = 15'(n);
                        phase   = PH_DUMP;
                     end
                  end
               end
            end
            default: begin
               phase = PH_OP;
               if (b == OP_SHORT_RUN) begin
                  phase = PH_RUN_COUNT;
               end else if (b < OP_LONG_FORM) begin
                  pending = {7'd0, b};
                  phase   = PH_DUMP;
               end else if (b == OP_LONG_FORM) begin
                  long_form = 1'b0;
                  phase     = PH_WORD;
               end else begin
                  position = position + 16'(b[6:0]);
               end
            end
         endcase
      endfunction

      task report_mismatch(string what, int expected_val, int got_val);
         errors++;
         $display("%0t: span mismatch on %s: expected %0h, got %0h",
                  $realtime, what, expected_val, got_val);
      endtask

      task check_span(logic [15:0] start, logic [13:0] len, logic [7:0] val,
                      logic done, logic oof);
         rsd_span_type s;
         if (span_q.size() == 0) begin
            report_mismatch("unexpected span start", 0, start);
         end else begin
            s = span_q.pop_front();
            if (start !== s.span_start)   report_mismatch("span_start", s.span_start, start);
            if (len !== s.span_length)    report_mismatch("span_length", s.span_length, len);
            if (val !== s.pixel_value)    report_mismatch("pixel_value", s.pixel_value, val);
            if (done !== s.frame_done)    report_mismatch("frame_done", s.frame_done, done);
            if (oof !== s.out_of_frame)   report_mismatch("out_of_frame", s.out_of_frame, oof);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_code_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_span_start;
   logic [13:0] rsp_span_length;
   logic [7:0]  rsp_pixel_value;
   logic        rsp_frame_done;
   logic        rsp_out_of_frame;

   span_scoreboard sb = new();

   int   items_sent = 0;
   bit   sender_gaps_on = 1'b1;
   bit   receiver_stalls_on = 1'b1;
   logic hold_off_request = 1'b0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;

   run_skip_dump_decoder_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_span_start   (rsp_span_start),
      .rsp_span_length  (rsp_span_length),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_out_of_frame (rsp_out_of_frame)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sender gap: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!sender_gaps_on || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Offer one item and hold it until the block takes it. Valid stays high
   // afterwards; the next call either keeps it up or drops it for a gap.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      items_sent++;
   endtask

   task automatic send_short_dump(input int count);
      send_byte(8'(count));
      repeat (count) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_short_run(input logic [7:0] count, input logic [7:0] value);
      send_byte(OP_SHORT_RUN);
      send_byte(count);
      send_byte(value);
   endtask

   task automatic send_long_word(input logic [15:0] word);
      send_byte(OP_LONG_FORM);
      send_byte(word[7:0]);
      send_byte(word[15:8]);
   endtask

   task automatic send_long_run(input logic [13:0] count, input logic [7:0] value);
      send_long_word(LONG_RUN_BASE | {2'b00, count});
      send_byte(value);
   endtask

   task automatic send_long_dump(input logic [13:0] count);
      send_long_word(LONG_DUMP_BASE | {2'b00, count});
      repeat (int'(count)) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Drop valid and wait for every owed span; the loop waits on the clock before
   // its test so valid never gets two assignments in one step.
   task automatic wait_for_spans();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.span_q.size() != 0);
   endtask

   // Walk the decoder back to the opcode phase after stray bytes. Keep the
   // high byte of a long-form word below the dump marker so that no huge
   // literal dump gets started by accident.
   task automatic resync_to_opcode();
      while (sb.phase != PH_OP) begin
         if (sb.phase == PH_WORD && sb.long_form)
            send_byte(8'($urandom_range(0, 127)));
         else
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_random_op();
      int r;
      resync_to_opcode();
      r = $urandom_range(0, 99);
      if (r < 22) begin
         send_short_dump(($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
                                                     : $urandom_range(1, 10));
      end else if (r < 38) begin
         send_short_run(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (r < 50) begin
         send_byte(OP_LONG_FORM | 8'($urandom_range(1, 127)));
      end else if (r < 60) begin
         send_long_word(16'($urandom_range(1, 16'h7FFF)));
      end else if (r < 70) begin
         send_long_dump(($urandom_range(0, 29) == 0) ? 14'($urandom_range(0, 300))
                                                     : 14'($urandom_range(0, 12)));
      end else if (r < 80) begin
         send_long_run(($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 16383))
                                                   : 14'($urandom_range(0, 20)),
                       8'($urandom_range(0, 255)));
      end else if (r < 85) begin
         send_long_word(WORD_STOP);
      end else begin
         // stray bytes, decoded from whatever phase they land in; a word's
         // high byte stays below the dump marker here too
         repeat ($urandom_range(1, 4)) begin
            if (sb.phase == PH_WORD && sb.long_form)
               send_byte(8'($urandom_range(0, 127)));
            else
               send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Receiver: check each accepted span, then decide the stall for the next
   // cycle. A hold-off request from the stimulus holds the channel for a long
   // fixed stretch so that the block backs up into its input.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check_span(rsp_span_start, rsp_span_length, rsp_pixel_value,
                          rsp_frame_done, rsp_out_of_frame);
         if ($urandom_range(0, 149) == 0)
            receiver_stalls_on = !receiver_stalls_on;
         if (hold_off_request && hold_left == 0) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_request <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!receiver_stalls_on || $urandom_range(0, 99) < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[run_skip_dump_decoder_core] ERROR");
         $finish;
      end
   end

   initial begin
      bit held_off;
      bit drained;
      held_off = 1'b0;
      drained  = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every opcode, zero counts and stop.
      send_short_dump(1);
      send_short_run(8'd255, 8'hFF);
      send_short_run(8'd0, 8'h55);
      send_byte(OP_LONG_FORM | 8'h7F);
      send_long_word(16'h7FFF);
      send_long_run(14'h3FFF, 8'h00);
      send_long_run(14'd0, 8'h11);
      send_long_dump(14'd0);
      send_long_word(WORD_STOP);
      wait_for_spans();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0)
            sender_gaps_on = !sender_gaps_on;

         if (!held_off && items_sent >= 400) begin
            // Back-pressure: receiver holds off while a maximal short-form dump keeps
            // offering bytes at full rate.
            held_off = 1'b1;
            resync_to_opcode();
            sender_gaps_on = 1'b0;
            hold_off_request <= 1'b1;
            send_short_dump(127);
            sender_gaps_on = 1'b1;
         end else if (!drained && items_sent >= 750) begin
            drained = 1'b1;
            wait_for_spans();
         end else begin
            send_random_op();
         end
      end

      wait_for_spans();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.span_q.size() == 0) begin
         $display("[run_skip_dump_decoder_core] OK");
      end else begin
         $display("[run_skip_dump_decoder_core] ERROR");
      end
      $finish;
   end

endmodule
